@@ src/pmaa_pkg.sv @@
// Shared types and helpers for the penultimate min/max anti-alias filter.
// Holds the neighbour word decoder and the top-two / bottom-two merge functions.
// No dependencies.
package pmaa_pkg;

  localparam int unsigned NumNbr  = 6;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CvgW    = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned NumChan = 3;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [CvgW-1:0]  cvg_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic {
    FMT_RGBA5551 = 1'b0,
    FMT_RGBA8888 = 1'b1
  } pix_fmt_e;

  localparam pix_fmt_e FmtReset = FMT_RGBA8888;

  localparam cvg_t  CvgFull  = 3'd7;
  localparam logic [1:0] HiddenFull = 2'd3;
  localparam chan_t ChanMin  = 8'h00;
  localparam chan_t ChanMax  = 8'hff;

  // Decoded neighbour: colour channels and whether it has full coverage.
  typedef struct packed {
    logic  full;
    chan_t red;
    chan_t green;
    chan_t blue;
  } nbr_t;

  // The two most extreme values seen so far, most extreme first.
  typedef struct packed {
    chan_t first;
    chan_t second;
  } ext2_t;

  function automatic nbr_t decode_nbr(input word_t w, input pix_fmt_e fmt);
    nbr_t n;
    if (fmt == FMT_RGBA8888) begin
      n.full  = (w[7:5] == CvgFull);
      n.red   = w[31:24];
      n.green = w[23:16];
      n.blue  = w[15:8];
    end else begin
      n.full  = (w[17:16] == HiddenFull) && w[0];
      n.red   = {w[15:11], 3'b000};
      n.green = {w[10:6], 3'b000};
      n.blue  = {w[5:1], 3'b000};
    end
    return n;
  endfunction

  function automatic chan_t max2(input chan_t a, input chan_t b);
    return (a >= b) ? a : b;
  endfunction

  function automatic chan_t min2(input chan_t a, input chan_t b);
    return (a <= b) ? a : b;
  endfunction

  // Merge two top-two sets into the top two of their union.
  function automatic ext2_t merge_max(input ext2_t a, input ext2_t b);
    ext2_t r;
    if (a.first >= b.first) begin
      r.first  = a.first;
      r.second = max2(a.second, b.first);
    end else begin
      r.first  = b.first;
      r.second = max2(a.first, b.second);
    end
    return r;
  endfunction

  // Merge two bottom-two sets into the bottom two of their union.
  function automatic ext2_t merge_min(input ext2_t a, input ext2_t b);
    ext2_t r;
    if (a.first <= b.first) begin
      r.first  = a.first;
      r.second = min2(a.second, b.first);
    end else begin
      r.first  = b.first;
      r.second = min2(a.first, b.second);
    end
    return r;
  endfunction

endpackage

@@ src/pmaa_chan.sv @@
// One colour channel of the filter: penultimate max and min over the centre
// and six neighbours, then the coverage-weighted blend. Purely combinational.
// Depends on pmaa_pkg.
module pmaa_chan (
  input  pmaa_pkg::chan_t                 center_i,
  input  pmaa_pkg::cvg_t                  coverage_i,
  input  pmaa_pkg::chan_t [pmaa_pkg::NumNbr-1:0] nbr_i,
  output pmaa_pkg::chan_t                 result_o
);

  pmaa_pkg::ext2_t mx01, mx23, mx45, mx6, mx03, mx46, mx_all;
  pmaa_pkg::ext2_t mn01, mn23, mn45, mn6, mn03, mn46, mn_all;
  pmaa_pkg::chan_t pmax, pmin;
  pmaa_pkg::cvg_t  coeff;
  logic [10:0]     diff, prod, rounded;

  // Non-qualifying neighbours arrive as copies of the centre, which leaves
  // both penultimate extremes unchanged.
  always_comb begin
    mx01 = '{first: pmaa_pkg::max2(center_i, nbr_i[0]),
             second: pmaa_pkg::min2(center_i, nbr_i[0])};
    mx23 = '{first: pmaa_pkg::max2(nbr_i[1], nbr_i[2]),
             second: pmaa_pkg::min2(nbr_i[1], nbr_i[2])};
    mx45 = '{first: pmaa_pkg::max2(nbr_i[3], nbr_i[4]),
             second: pmaa_pkg::min2(nbr_i[3], nbr_i[4])};
    mx6  = '{first: nbr_i[5], second: pmaa_pkg::ChanMin};
    mx03   = pmaa_pkg::merge_max(mx01, mx23);
    mx46   = pmaa_pkg::merge_max(mx45, mx6);
    mx_all = pmaa_pkg::merge_max(mx03, mx46);

    mn01 = '{first: pmaa_pkg::min2(center_i, nbr_i[0]),
             second: pmaa_pkg::max2(center_i, nbr_i[0])};
    mn23 = '{first: pmaa_pkg::min2(nbr_i[1], nbr_i[2]),
             second: pmaa_pkg::max2(nbr_i[1], nbr_i[2])};
    mn45 = '{first: pmaa_pkg::min2(nbr_i[3], nbr_i[4]),
             second: pmaa_pkg::max2(nbr_i[3], nbr_i[4])};
    mn6  = '{first: nbr_i[5], second: pmaa_pkg::ChanMax};
    mn03   = pmaa_pkg::merge_min(mn01, mn23);
    mn46   = pmaa_pkg::merge_min(mn45, mn6);
    mn_all = pmaa_pkg::merge_min(mn03, mn46);

    // The centre stands when no neighbour lies beyond it.
    pmax = (mx_all.first > center_i) ? mx_all.second : center_i;
    pmin = (mn_all.first < center_i) ? mn_all.second : center_i;
  end

  // Only bits 10:3 of the scaled difference reach the 8-bit result.
  assign coeff    = pmaa_pkg::CvgFull - coverage_i;
  assign diff     = {3'b000, pmin} + {3'b000, pmax} - {2'b00, center_i, 1'b0};
  assign prod     = 11'(diff * {8'b0000_0000, coeff});
  assign rounded  = prod + 11'd4;
  assign result_o = rounded[10:3] + center_i;

endmodule

@@ src/penultimate_minmax_antialias_filter_core.sv @@
// Top level of the penultimate min/max anti-alias filter.
// Depends on pmaa_pkg and pmaa_chan.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one centre pixel, its
//   coverage and six neighbour words per transfer. Output channel
//   (out_valid_o / out_stall_i) carries the filtered RGB colour, one result
//   per input transfer, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes pixel_format;
//   cfg_ready_o is always high. Write it only while the pipeline is empty.
//   The input register captures an accepted transfer; the result register
//   then loads it when free, and it transfers from there.
//   Throughput: one item per cycle while the output is not stalled; the input
//   register feeds the neighbour decode, per-channel penultimate extremes and
//   blend, all combinational and registered into the output register.
//   Reset empties both stages and sets pixel_format to 32-bit mode.
//   Output stall holds the result register; the input register keeps the
//   next item and in_stall_o rises only when both stages are full.
module penultimate_minmax_antialias_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  center_red_i,
  input  logic [7:0]  center_green_i,
  input  logic [7:0]  center_blue_i,
  input  logic [2:0]  center_coverage_i,
  input  logic [31:0] upper_left_word_i,
  input  logic [31:0] upper_right_word_i,
  input  logic [31:0] left_word_i,
  input  logic [31:0] right_word_i,
  input  logic [31:0] lower_left_word_i,
  input  logic [31:0] lower_right_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);

  pmaa_pkg::pix_fmt_e fmt_q;

  logic in_valid_q, out_valid_q;
  logic in_accept, out_load;

  pmaa_pkg::chan_t [pmaa_pkg::NumChan-1:0] center_q;
  pmaa_pkg::cvg_t                          cvg_q;
  pmaa_pkg::word_t [pmaa_pkg::NumNbr-1:0]  word_q;

  pmaa_pkg::nbr_t  [pmaa_pkg::NumNbr-1:0]  nbr;
  pmaa_pkg::chan_t [pmaa_pkg::NumNbr-1:0]  nbr_red, nbr_green, nbr_blue;
  pmaa_pkg::chan_t [pmaa_pkg::NumChan-1:0] result;
  pmaa_pkg::chan_t [pmaa_pkg::NumChan-1:0] out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pmaa_pkg::FmtReset;
    end else if (cfg_valid_i) begin
      fmt_q <= pmaa_pkg::pix_fmt_e'(cfg_data_i);
    end
  end

  // Output register advances whenever it is empty or being taken.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      center_q  <= {center_blue_i, center_green_i, center_red_i};
      cvg_q     <= center_coverage_i;
      word_q    <= {lower_right_word_i, lower_left_word_i, right_word_i,
                    left_word_i, upper_right_word_i, upper_left_word_i};
    end
  end

  // Replace neighbours without full coverage by the centre colour.
  always_comb begin
    for (int i = 0; i < pmaa_pkg::NumNbr; i++) begin
      nbr[i]       = pmaa_pkg::decode_nbr(word_q[i], fmt_q);
      nbr_red[i]   = nbr[i].full ? nbr[i].red   : center_q[0];
      nbr_green[i] = nbr[i].full ? nbr[i].green : center_q[1];
      nbr_blue[i]  = nbr[i].full ? nbr[i].blue  : center_q[2];
    end
  end

  pmaa_chan u_chan_red (
    .center_i   (center_q[0]),
    .coverage_i (cvg_q),
    .nbr_i      (nbr_red),
    .result_o   (result[0])
  );

  pmaa_chan u_chan_green (
    .center_i   (center_q[1]),
    .coverage_i (cvg_q),
    .nbr_i      (nbr_green),
    .result_o   (result[1])
  );

  pmaa_chan u_chan_blue (
    .center_i   (center_q[2]),
    .coverage_i (cvg_q),
    .nbr_i      (nbr_blue),
    .result_o   (result[2])
  );

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule

@@ src/pmaa_checker.sv @@
// Port-level checks for the penultimate min/max anti-alias filter,
// bound to the top level. Depends on penultimate_minmax_antialias_filter_core.
module pmaa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_red_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_blue_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_red_o) && $stable(out_green_o) && $stable(out_blue_o))
    else $error("stalled result changed");

  // Drop a result only after its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without transfer");

  // Never push back while the output register can advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled with output free");

  // Once an accepted item has passed the input register, the output is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind penultimate_minmax_antialias_filter_core pmaa_checker u_pmaa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_red_o   (out_red_o),
  .out_green_o (out_green_o),
  .out_blue_o  (out_blue_o)
);

@@ bench/pmaa_tb_pkg.sv @@
// Bench types and the colour scoreboard for the penultimate min/max anti-alias filter.
// Depends on pmaa_pkg for channel, coverage, word and pixel format types.
package pmaa_tb_pkg;
  import pmaa_pkg::*;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    cvg_t  cvg;
    word_t nbr [NumNbr];
  } pixel_in_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  class colour_scoreboard;
    rgb_t        expected_q [$];
    pix_fmt_e    fmt;
    int unsigned faults;

    function new();
      fmt    = FmtReset;
      faults = 0;
    endfunction

    function void set_format(pix_fmt_e f);
      fmt = f;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Second most extreme of the candidate list; the centre sits at index 0.
    function chan_t runner_up(input chan_t v [NumNbr+1], input int unsigned n,
                              input bit want_max);
      int unsigned pos;
      chan_t       best;
      bit          have;
      pos  = 0;
      best = ChanMin;
      have = 1'b0;
      for (int unsigned i = 1; i < n; i++) begin
        if (want_max ? (v[i] > v[pos]) : (v[i] < v[pos])) pos = i;
      end
      if (pos == 0) return v[0];
      for (int unsigned i = 0; i < n; i++) begin
        if (i != pos && (!have || (want_max ? (v[i] > best) : (v[i] < best)))) begin
          best = v[i];
          have = 1'b1;
        end
      end
      return best;
    endfunction

    // All arithmetic wraps at 32 bits; keep the low byte.
    function chan_t blend_chan(input chan_t c, input chan_t lo, input chan_t hi,
                               input cvg_t cvg);
      logic [31:0] diff;
      logic [31:0] acc;
      diff = 32'(lo) + 32'(hi) - (32'(c) << 1);
      acc  = ((diff * (32'd7 - 32'(cvg)) + 32'd4) >> 3) + 32'(c);
      return acc[7:0];
    endfunction

    function rgb_t filter_pixel(input pixel_in_t p);
      chan_t       lists [NumChan][NumNbr+1];
      chan_t       centre [NumChan];
      chan_t       res [NumChan];
      int unsigned n;
      word_t       w;
      rgb_t        r;
      centre[0] = p.red;
      centre[1] = p.green;
      centre[2] = p.blue;
      for (int ch = 0; ch < NumChan; ch++) lists[ch][0] = centre[ch];
      n = 1;
      for (int i = 0; i < NumNbr; i++) begin
        w = p.nbr[i];
        if (fmt == FMT_RGBA8888) begin
          if (w[7:5] == CvgFull) begin
            lists[0][n] = w[31:24];
            lists[1][n] = w[23:16];
            lists[2][n] = w[15:8];
            n++;
          end
        end else if (w[17:16] == HiddenFull && w[0]) begin
          lists[0][n] = {w[15:11], 3'b000};
          lists[1][n] = {w[10:6], 3'b000};
          lists[2][n] = {w[5:1], 3'b000};
          n++;
        end
      end
      for (int ch = 0; ch < NumChan; ch++) begin
        res[ch] = blend_chan(centre[ch], runner_up(lists[ch], n, 1'b0),
                             runner_up(lists[ch], n, 1'b1), p.cvg);
      end
      r.red   = res[0];
      r.green = res[1];
      r.blue  = res[2];
      return r;
    endfunction

    function void note_pixel(input pixel_in_t p);
      expected_q.push_back(filter_pixel(p));
    endfunction

    function void check_colour(input rgb_t got);
      rgb_t want;
      if (expected_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected colour: got %02h %02h %02h", got.red, got.green, got.blue);
        return;
      end
      want = expected_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        faults++;
        if (faults <= 10)
          $display("colour mismatch: expected %02h %02h %02h, got %02h %02h %02h",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
// Top-level bench for penultimate_minmax_antialias_filter_core: drives pixels and
// format writes, stalls the output at random. Depends on pmaa_pkg and pmaa_tb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pmaa_pkg::*;
  import pmaa_tb_pkg::*;

  localparam int unsigned PipeDepth = 2;
  localparam int unsigned MaxGap    = 14;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned PhaseLen  = 215;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  center_red_i = '0;
  logic [7:0]  center_green_i = '0;
  logic [7:0]  center_blue_i = '0;
  logic [2:0]  center_coverage_i = '0;
  logic [31:0] nbr_word [NumNbr] = '{default: '0};
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;

  bit               calm = 1'b0;
  colour_scoreboard sb = new();

  penultimate_minmax_antialias_filter_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .center_red_i      (center_red_i),
    .center_green_i    (center_green_i),
    .center_blue_i     (center_blue_i),
    .center_coverage_i (center_coverage_i),
    .upper_left_word_i (nbr_word[0]),
    .upper_right_word_i(nbr_word[1]),
    .left_word_i       (nbr_word[2]),
    .right_word_i      (nbr_word[3]),
    .lower_left_word_i (nbr_word[4]),
    .lower_right_word_i(nbr_word[5]),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_red_o         (out_red_o),
    .out_green_o       (out_green_o),
    .out_blue_o        (out_blue_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic word_t w8888(chan_t r, chan_t g, chan_t b, cvg_t cov, logic [4:0] low);
    return {r, g, b, cov, low};
  endfunction

  function automatic word_t w5551(logic [4:0] r, logic [4:0] g, logic [4:0] b, logic a,
                                  logic [1:0] hid, logic [13:0] upper);
    return {upper, hid, r, g, b, a};
  endfunction

  function automatic pixel_in_t uniform(chan_t r, chan_t g, chan_t b, cvg_t c, word_t w);
    pixel_in_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.cvg   = c;
    for (int i = 0; i < NumNbr; i++) p.nbr[i] = w;
    return p;
  endfunction

  // Bias neighbour levels towards the centre and the rails so ties and extremes occur.
  function automatic chan_t pick_level(chan_t centre);
    case ($urandom_range(0, 6))
      4:       return centre;
      5:       return ChanMin;
      6:       return ChanMax;
      default: return chan_t'($urandom());
    endcase
  endfunction

  function automatic pixel_in_t random_pixel(pix_fmt_e f);
    pixel_in_t p;
    word_t     w;
    chan_t     r;
    chan_t     g;
    chan_t     b;
    p.red   = chan_t'($urandom());
    p.green = chan_t'($urandom());
    p.blue  = chan_t'($urandom());
    p.cvg   = cvg_t'($urandom());
    if (f == FMT_RGBA5551 && $urandom_range(0, 1) == 1) begin
      p.red[2:0]   = 3'b000;
      p.green[2:0] = 3'b000;
      p.blue[2:0]  = 3'b000;
    end
    for (int i = 0; i < NumNbr; i++) begin
      w = $urandom();
      r = pick_level(p.red);
      g = pick_level(p.green);
      b = pick_level(p.blue);
      // Most neighbours are fully covered; the rest are noise.
      if (f == FMT_RGBA8888) begin
        if ($urandom_range(0, 3) != 0) w[7:5] = CvgFull;
        w[31:8] = {r, g, b};
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          w[17:16] = HiddenFull;
          w[0]     = 1'b1;
        end
        w[15:1] = {r[7:3], g[7:3], b[7:3]};
      end
      p.nbr[i] = w;
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_in_t p);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    center_red_i      = p.red;
    center_green_i    = p.green;
    center_blue_i     = p.blue;
    center_coverage_i = p.cvg;
    for (int i = 0; i < NumNbr; i++) nbr_word[i] = p.nbr[i];
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(p);
    @(negedge clk_i);
  endtask

  // Hold the input until every result is back and the pipeline has emptied.
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_format(input pix_fmt_e f);
    cfg_data_i  = f;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_format(f);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic directed_8888();
    pixel_in_t p;
    send_pixel(uniform(8'd0, 8'd0, 8'd0, 3'd0, '0));
    send_pixel(uniform(8'd255, 8'd255, 8'd255, 3'd7, 32'hffff_ffff));
    send_pixel(uniform(8'd0, 8'd0, 8'd0, 3'd0, 32'hffff_ffff));
    send_pixel(uniform(8'd255, 8'd255, 8'd255, 3'd1, w8888(8'd0, 8'd0, 8'd0, CvgFull, 5'd0)));
    // one qualifying neighbour: above, below and equal to the centre
    p = uniform(8'd100, 8'd100, 8'd100, 3'd2, w8888(8'd200, 8'd50, 8'd150, 3'd6, 5'h1f));
    p.nbr[3] = w8888(8'd200, 8'd50, 8'd100, CvgFull, 5'd0);
    send_pixel(p);
    p = uniform(8'd128, 8'd128, 8'd128, 3'd3, '0);
    p.nbr[0] = w8888(8'd200, 8'd10, 8'd128, CvgFull, 5'd0);
    p.nbr[5] = w8888(8'd250, 8'd5, 8'd129, CvgFull, 5'h1f);
    send_pixel(p);
    // repeated extreme
    p = uniform(8'd60, 8'd60, 8'd60, 3'd4, w8888(8'd90, 8'd30, 8'd60, CvgFull, 5'd0));
    p.nbr[2] = w8888(8'd120, 8'd20, 8'd200, CvgFull, 5'd0);
    p.nbr[4] = w8888(8'd120, 8'd20, 8'd10, CvgFull, 5'd0);
    send_pixel(p);
    send_pixel(uniform(8'd255, 8'd0, 8'd128, 3'd5, w8888(8'd10, 8'd250, 8'd128, CvgFull, 5'd0)));
    p = uniform(8'd50, 8'd50, 8'd50, 3'd6, w8888(8'd255, 8'd255, 8'd255, 3'b011, 5'h1f));
    p.nbr[1] = w8888(8'd0, 8'd0, 8'd0, 3'b110, 5'd0);
    send_pixel(p);
    p = uniform(8'd77, 8'd177, 8'd7, 3'd0, '0);
    for (int i = 0; i < NumNbr; i++)
      p.nbr[i] = w8888(chan_t'(i * 50), chan_t'(255 - i * 40), chan_t'(i * 30), CvgFull,
                       5'(i));
    send_pixel(p);
  endtask

  task automatic directed_5551();
    pixel_in_t p;
    send_pixel(uniform(8'd0, 8'd0, 8'd0, 3'd0, '0));
    send_pixel(uniform(8'd255, 8'd255, 8'd255, 3'd7, 32'hffff_ffff));
    send_pixel(uniform(8'd0, 8'd0, 8'd0, 3'd3, w5551(5'd31, 5'd31, 5'd31, 1'b1, HiddenFull, '0)));
    // hidden bits short of full, or pixel bit 0 clear: no neighbour counts
    p = uniform(8'd8, 8'd8, 8'd8, 3'd1, w5551(5'd31, 5'd0, 5'd31, 1'b1, 2'b10, 14'h3fff));
    p.nbr[2] = w5551(5'd31, 5'd0, 5'd31, 1'b0, HiddenFull, '0);
    p.nbr[3] = w5551(5'd0, 5'd31, 5'd0, 1'b1, 2'b01, '0);
    send_pixel(p);
    p = uniform(8'd120, 8'd40, 8'd200, 3'd5, '0);
    p.nbr[4] = w5551(5'd20, 5'd2, 5'd30, 1'b1, HiddenFull, 14'h2aaa);
    send_pixel(p);
    p = uniform(8'd128, 8'd64, 8'd32, 3'd2, '0);
    for (int i = 0; i < NumNbr; i++)
      p.nbr[i] = w5551(5'(i * 6), 5'(31 - i * 5), 5'(i * 3 + 5), 1'b1, HiddenFull,
                       14'(~i));
    send_pixel(p);
    p = uniform(8'd80, 8'd80, 8'd80, 3'd6, w5551(5'd10, 5'd10, 5'd10, 1'b1, HiddenFull, '0));
    p.nbr[0] = w5551(5'd12, 5'd8, 5'd10, 1'b1, HiddenFull, '0);
    p.nbr[1] = w5551(5'd12, 5'd8, 5'd10, 1'b1, HiddenFull, '0);
    send_pixel(p);
    send_pixel(uniform(8'd248, 8'd0, 8'd128, 3'd4,
                       w5551(5'd0, 5'd31, 5'd16, 1'b1, HiddenFull, 14'h1555)));
  endtask

  initial begin
    pix_fmt_e f;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed_8888();
    drain();
    write_format(FMT_RGBA5551);
    directed_5551();
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      f = (ph < 4) ? pix_fmt_e'(~ph[0]) : pix_fmt_e'($urandom_range(0, 1));
      write_format(f);
      for (int k = 0; k < PhaseLen; k++) begin
        calm = ((k / 40) % 5 == 4);
        send_pixel(random_pixel(f));
      end
      calm = 1'b0;
    end
    drain();
    if (sb.faults == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Accept results, with a random stall drawn before each transfer.
  initial begin
    int unsigned gap;
    rgb_t        got;
    wait (rst_ni);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.red   = out_red_o;
      got.green = out_green_o;
      got.blue  = out_blue_o;
      sb.check_colour(got);
      @(negedge clk_i);
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
src/pmaa_pkg.sv
src/pmaa_chan.sv
src/penultimate_minmax_antialias_filter_core.sv
src/pmaa_checker.sv
bench/pmaa_tb_pkg.sv
bench/tb_top.sv
